@@ design/gvs_pkg.sv @@
// ----------------------------------------------------------------------------
// gvs_pkg: shared types and constants of the GC victim selector
// Event codes, configuration register indexes, field widths and reset values.
// ----------------------------------------------------------------------------
package gvs_pkg;

  // Field widths fixed by the word format
  localparam int HANDLE_W   = 32;
  localparam int MAXRUN_W   = 4;
  localparam int THRESH_W   = 17;
  localparam int KIND_W     = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 17;

  // Q16 fixed point: 1.0 is 1 << 16
  localparam int Q16_SHIFT = 16;
  localparam logic [THRESH_W-1:0] Q16_ONE = THRESH_W'(1) << Q16_SHIFT;

  // Defaults for the top level parameters
  localparam int DEF_MAX_RUNNING = 8;
  localparam int DEF_COUNT_BITS  = 24;

  // Configuration reset values
  localparam logic [MAXRUN_W-1:0] RST_MAX_RUNNING = MAXRUN_W'(1);
  localparam logic [THRESH_W-1:0] RST_THRESHOLD   = THRESH_W'(32768);

  typedef enum logic [KIND_W-1:0] {
    KIND_SCAN_BEGIN = 2'd0,
    KIND_ENTRY      = 2'd1,
    KIND_SCAN_END   = 2'd2,
    KIND_FINISHED   = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_RUNNING       = 1'd0,
    REG_GARBAGE_THRESHOLD = 1'd1
  } cfg_reg_t;

endpackage

@@ design/gvs_if.sv @@
// ----------------------------------------------------------------------------
// gvs_if: word channels of the GC victim selector
// Event input channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface gvs_in_if #(
  parameter int COUNT_BITS = gvs_pkg::DEF_COUNT_BITS
);
  logic                          valid;
  logic                          ready;
  logic [gvs_pkg::KIND_W-1:0]    kind;
  logic [gvs_pkg::HANDLE_W-1:0]  chunk_handle;
  logic                          sealed;
  logic [COUNT_BITS-1:0]         referenced_blocks;
  logic [COUNT_BITS-1:0]         written_blocks;
  logic                          failed;

  modport source (
    output valid, kind, chunk_handle, sealed, referenced_blocks, written_blocks, failed,
    input  ready
  );
  modport sink (
    input  valid, kind, chunk_handle, sealed, referenced_blocks, written_blocks, failed,
    output ready
  );
endinterface

interface gvs_out_if;
  logic                          valid;
  logic                          ready;
  logic                          launched;
  logic [gvs_pkg::HANDLE_W-1:0]  victim_handle;
  logic                          error_pending;

  modport source (
    output valid, launched, victim_handle, error_pending,
    input  ready
  );
  modport sink (
    input  valid, launched, victim_handle, error_pending,
    output ready
  );
endinterface

@@ design/gvs_ratio_cmp.sv @@
// ----------------------------------------------------------------------------
// gvs_ratio_cmp: garbage ratio compare
// Exact test of 1 - ra/wa > 1 - rb/wb by cross-multiplication; zero written
// counts as ratio zero.
// ----------------------------------------------------------------------------
module gvs_ratio_cmp #(
  parameter int COUNT_BITS = gvs_pkg::DEF_COUNT_BITS
) (
  input  logic [COUNT_BITS-1:0] ra,
  input  logic [COUNT_BITS-1:0] wa,
  input  logic [COUNT_BITS-1:0] rb,
  input  logic [COUNT_BITS-1:0] wb,
  output logic                  greater
);
  localparam int PW = 2 * COUNT_BITS;

  logic [PW-1:0] prod_a;
  logic [PW-1:0] prod_b;
  logic          wa_zero;
  logic          wb_zero;

  assign prod_a  = PW'(ra) * PW'(wb);
  assign prod_b  = PW'(rb) * PW'(wa);
  assign wa_zero = (wa == '0);
  assign wb_zero = (wb == '0);

  always_comb begin
    priority if (!wa_zero && !wb_zero) begin
      greater = (prod_a < prod_b);
    end else if (wa_zero && !wb_zero) begin
      // b has a negative ratio when referenced exceeds written
      greater = (rb > wb);
    end else if (!wa_zero && wb_zero) begin
      greater = (ra < wa);
    end else begin
      greater = 1'b0;
    end
  end

endmodule

@@ design/greedy_gc_victim_selector_top.sv @@
// ----------------------------------------------------------------------------
// greedy_gc_victim_selector_top: greedy garbage-collection victim selector
// Path: a scan-end word's result reaches out_ch through the input register,
//   then the result register; a held result word keeps it in the input register.
// Throughput: one word per cycle while no held result word stalls a scan end;
//   only a scan end waits on the result register, other words move on freely.
// Reset: synchronous, active low; running set empty, no best entry, error
//   latch clear, max_running = 1, garbage_threshold = 0.5.
// ----------------------------------------------------------------------------
module greedy_gc_victim_selector_top #(
  parameter int MAX_RUNNING = gvs_pkg::DEF_MAX_RUNNING,
  parameter int COUNT_BITS  = gvs_pkg::DEF_COUNT_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  gvs_in_if.sink                           in_ch,
  gvs_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [gvs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gvs_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import gvs_pkg::*;

  localparam int CNT_W = $clog2(MAX_RUNNING + 1);
  localparam int CMP_W = (CNT_W > MAXRUN_W) ? CNT_W : MAXRUN_W;
  localparam int TPW   = THRESH_W + COUNT_BITS;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [MAXRUN_W-1:0] max_run_r;
  logic [THRESH_W-1:0] thresh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_run_r <= RST_MAX_RUNNING;
      thresh_r  <= RST_THRESHOLD;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MAX_RUNNING:       max_run_r <= cfg_wdata[MAXRUN_W-1:0];
        REG_GARBAGE_THRESHOLD: thresh_r  <= cfg_wdata[THRESH_W-1:0];
        default:               ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Input stage: the threshold test depends only on the word and on config,
  // so it is resolved here and carried as one candidate bit.
  // --------------------------------------------------------------------------
  logic                  thr_in_range;
  logic [THRESH_W-1:0]   thr_rem;
  logic [TPW-1:0]        thr_lhs;
  logic [TPW-1:0]        thr_rhs;
  logic                  thr_ok;
  logic                  cand_in;

  assign thr_in_range = (thresh_r <= Q16_ONE);
  assign thr_rem      = Q16_ONE - thresh_r;
  assign thr_lhs      = TPW'(thr_rem) * TPW'(in_ch.written_blocks);
  assign thr_rhs      = TPW'({in_ch.referenced_blocks, {Q16_SHIFT{1'b0}}});

  always_comb begin
    priority if (!thr_in_range) begin
      thr_ok = 1'b0;
    end else if (in_ch.written_blocks == '0) begin
      thr_ok = (thresh_r == '0);
    end else begin
      thr_ok = (thr_lhs >= thr_rhs);
    end
  end

  assign cand_in = in_ch.sealed && (in_ch.referenced_blocks != '0) && thr_ok;

  logic                  in_v_r;
  kind_t                 kind_r;
  logic [HANDLE_W-1:0]   handle_r;
  logic [COUNT_BITS-1:0] ref_r;
  logic [COUNT_BITS-1:0] wr_r;
  logic                  failed_r;
  logic                  cand_r;

  logic                  fire;
  logic                  out_free;
  logic                  in_acc;

  // Output register is free when empty or being drained this cycle
  assign out_free    = !out_ch.valid || out_ch.ready;
  assign fire        = in_v_r && ((kind_r != KIND_SCAN_END) || out_free);
  assign in_ch.ready = !in_v_r || fire;
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_acc) begin
      in_v_r <= 1'b1;
    end else if (fire) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      kind_r   <= kind_t'(in_ch.kind);
      handle_r <= in_ch.chunk_handle;
      ref_r    <= in_ch.referenced_blocks;
      wr_r     <= in_ch.written_blocks;
      failed_r <= in_ch.failed;
      cand_r   <= cand_in;
    end
  end

  // --------------------------------------------------------------------------
  // Running set: handles are only looked at under their valid bit, so the
  // handle registers carry no reset.
  // --------------------------------------------------------------------------
  logic [MAX_RUNNING-1:0] run_valid_r;
  logic [HANDLE_W-1:0]    run_handle_r [MAX_RUNNING];

  logic [MAX_RUNNING-1:0] hit_vec;
  logic [MAX_RUNNING-1:0] hit_oh;
  logic [MAX_RUNNING-1:0] free_oh;
  logic                   hit_any;
  logic                   free_any;
  logic [CNT_W-1:0]       run_cnt;

  always_comb begin
    for (int i = 0; i < MAX_RUNNING; i++) begin
      hit_vec[i] = run_valid_r[i] && (run_handle_r[i] == handle_r);
    end
  end

  // lowest matching slot, lowest free slot
  assign hit_oh   = hit_vec & (~hit_vec + MAX_RUNNING'(1));
  assign free_oh  = ~run_valid_r & (run_valid_r + MAX_RUNNING'(1));
  assign hit_any  = |hit_vec;
  assign free_any = |free_oh;

  always_comb begin
    run_cnt = '0;
    for (int i = 0; i < MAX_RUNNING; i++) begin
      run_cnt = run_cnt + CNT_W'(run_valid_r[i]);
    end
  end

  // --------------------------------------------------------------------------
  // Best-entry tracking
  // --------------------------------------------------------------------------
  logic                  best_valid_r;
  logic [HANDLE_W-1:0]   best_handle_r;
  logic [COUNT_BITS-1:0] best_ref_r;
  logic [COUNT_BITS-1:0] best_wr_r;
  logic                  err_latch_r;

  logic                  beats_best;

  gvs_ratio_cmp #(
    .COUNT_BITS (COUNT_BITS)
  ) u_ratio_cmp (
    .ra      (ref_r),
    .wa      (wr_r),
    .rb      (best_ref_r),
    .wb      (best_wr_r),
    .greater (beats_best)
  );

  logic is_begin;
  logic is_entry;
  logic is_end;
  logic is_finish;
  logic take_best;
  logic launch;
  logic err_nxt;

  assign is_begin  = fire && (kind_r == KIND_SCAN_BEGIN);
  assign is_entry  = fire && (kind_r == KIND_ENTRY);
  assign is_end    = fire && (kind_r == KIND_SCAN_END);
  assign is_finish = fire && (kind_r == KIND_FINISHED);

  // ties keep the earlier entry
  assign take_best = is_entry && !hit_any && cand_r && (!best_valid_r || beats_best);
  assign launch    = is_end && best_valid_r && free_any &&
                     (CMP_W'(run_cnt) < CMP_W'(max_run_r));

  always_comb begin
    err_nxt = err_latch_r;
    priority if (is_finish && hit_any) begin
      err_nxt = failed_r;
    end else if (is_end && !launch && (run_cnt == '0)) begin
      err_nxt = 1'b0;
    end else begin
      err_nxt = err_latch_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_valid_r  <= 1'b0;
      best_handle_r <= '0;
      best_ref_r    <= '0;
      best_wr_r     <= '0;
      err_latch_r   <= 1'b0;
      run_valid_r   <= '0;
    end else begin
      err_latch_r <= err_nxt;
      if (is_begin || is_end) begin
        best_valid_r  <= 1'b0;
        best_handle_r <= '0;
        best_ref_r    <= '0;
        best_wr_r     <= '0;
      end else if (take_best) begin
        best_valid_r  <= 1'b1;
        best_handle_r <= handle_r;
        best_ref_r    <= ref_r;
        best_wr_r     <= wr_r;
      end
      if (is_finish) begin
        run_valid_r <= run_valid_r & ~hit_oh;
      end else if (launch) begin
        run_valid_r <= run_valid_r | free_oh;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RUNNING; i++) begin
      if (launch && free_oh[i]) begin
        run_handle_r[i] <= best_handle_r;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  logic                out_valid_r;
  logic                launched_r;
  logic [HANDLE_W-1:0] victim_r;
  logic                err_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (is_end) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (is_end) begin
      launched_r <= launch;
      victim_r   <= launch ? best_handle_r : '0;
      err_out_r  <= err_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.launched      = launched_r;
  assign out_ch.victim_handle = victim_r;
  assign out_ch.error_pending = err_out_r;

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  a_out_from_end: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(is_end))
    else $error("result word without a scan end");

  a_one_launch: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(run_valid_r) <= $countones($past(run_valid_r)) + 1)
    else $error("running set grew by more than one");

  a_err_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(err_latch_r) |-> $past(is_finish && hit_any))
    else $error("error latch set without a known finish");

  a_launch_cap: assert property (@(posedge clk) disable iff (!rst_n)
    launch |=> ($countones(run_valid_r) <= MAX_RUNNING) && (run_cnt != '0))
    else $error("launch left the running set empty");

endmodule

@@ test/greedy_gc_victim_selector_top_tb.sv @@
// ----------------------------------------------------------------------------
// greedy_gc_victim_selector_top_tb: self-checking bench for the victim selector
// Streams scan begin / chunk entry / scan end / finished words, predicts each
// scan-end result word in a local model of the running set and best entry,
// and compares every result word field by field. Both channel sides idle at
// random; one phase holds the result side off long enough to stall the input.
// ----------------------------------------------------------------------------
module greedy_gc_victim_selector_top_tb;
  import gvs_pkg::*;

  localparam int CB            = DEF_COUNT_BITS;
  localparam int SLOTS         = DEF_MAX_RUNNING;
  localparam int SETTLE_CYCLES = 6;     // pipeline is two deep; margin on top
  localparam int STALL_LIMIT   = 2000;  // cycles with no handshake at all
  localparam int HOLD_CYCLES   = 150;   // long result-side hold-off
  localparam int RANDOM_WORDS  = 760;
  localparam int PHASES        = 8;

  typedef logic [CB-1:0]       count_t;
  typedef logic [HANDLE_W-1:0] handle_t;

  // one input word
  typedef struct {
    kind_t   kind;
    handle_t handle;
    logic    sealed;
    count_t  refd;
    count_t  wrt;
    logic    failed;
  } chunk_word_t;

  // one scan-end result word
  typedef struct {
    logic    launched;
    handle_t victim;
    logic    err;
  } verdict_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  gvs_in_if #(.COUNT_BITS(CB)) in_ch ();
  gvs_out_if                   out_ch ();

  greedy_gc_victim_selector_top #(
    .MAX_RUNNING(SLOTS),
    .COUNT_BITS (CB)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Selector model: running set, best entry so far, error latch, registers
  // --------------------------------------------------------------------------
  handle_t             slot_handle [SLOTS];
  logic                slot_busy   [SLOTS];
  logic                cand_valid;
  handle_t             cand_handle;
  count_t              cand_refd;
  count_t              cand_wrt;
  logic                fail_latch;
  logic [MAXRUN_W-1:0] lim_running;
  logic [THRESH_W-1:0] min_garbage;

  verdict_t pending_verdicts[$];   // scan-end results still to arrive
  int       mismatches = 0;
  int       words_sent = 0;
  bit       quiet      = 1'b0;     // both sides run without gaps while set
  int       hold_req   = 0;        // result-side hold-off request, in cycles

  function automatic void forget_candidate();
    cand_valid  = 1'b0;
    cand_handle = '0;
    cand_refd   = '0;
    cand_wrt    = '0;
  endfunction

  // garbage(ra/wa) > garbage(rb/wb), exact; zero written counts as ratio 0
  function automatic bit more_garbage(input longint unsigned ra, wa, rb, wb);
    if (wa != 0 && wb != 0) return ra * wb < rb * wa;
    if (wa == 0 && wb != 0) return rb > wb;
    if (wa != 0 && wb == 0) return ra < wa;
    return 1'b0;
  endfunction

  // 1 - r/w >= threshold, cross-multiplied in Q16
  function automatic bit garbage_enough(input longint unsigned r, w);
    longint unsigned t;
    longint unsigned one;
    t   = min_garbage;
    one = Q16_ONE;
    if (t > one) return 1'b0;
    if (w == 0) return t == 0;
    return (one - t) * w >= one * r;
  endfunction

  function automatic int busy_slot(input handle_t h);
    for (int i = 0; i < SLOTS; i++)
      if (slot_busy[i] && slot_handle[i] == h) return i;
    return -1;
  endfunction

  // advance the model by one accepted word; a scan end queues its result
  task automatic select_victim(input chunk_word_t w);
    int       slot;
    int       used;
    int       free_slot;
    verdict_t v;
    case (w.kind)
      KIND_SCAN_BEGIN: begin
        forget_candidate();
      end
      KIND_ENTRY: begin
        if (busy_slot(w.handle) < 0 && w.sealed && w.refd != 0 &&
            garbage_enough(w.refd, w.wrt) &&
            (!cand_valid || more_garbage(w.refd, w.wrt, cand_refd, cand_wrt))) begin
          cand_valid  = 1'b1;
          cand_handle = w.handle;
          cand_refd   = w.refd;
          cand_wrt    = w.wrt;
        end
      end
      KIND_FINISHED: begin
        slot = busy_slot(w.handle);
        if (slot >= 0) begin
          slot_busy[slot] = 1'b0;
          fail_latch      = w.failed;
        end
      end
      default: begin
        used      = 0;
        free_slot = -1;
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_busy[i]) used++;
          else if (free_slot < 0) free_slot = i;
        end
        v.launched = 1'b0;
        v.victim   = '0;
        if (used < lim_running && cand_valid && free_slot >= 0) begin
          slot_busy[free_slot]   = 1'b1;
          slot_handle[free_slot] = cand_handle;
          v.launched             = 1'b1;
          v.victim               = cand_handle;
        end
        if (!v.launched && used == 0) fail_latch = 1'b0;
        forget_candidate();
        v.err = fail_latch;
        pending_verdicts.insert(pending_verdicts.size(), v);
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Word builders
  // --------------------------------------------------------------------------
  function automatic chunk_word_t mk(input kind_t k, input handle_t h, input logic s,
                                     input count_t r, input count_t wr, input logic f);
    chunk_word_t w;
    w.kind   = k;
    w.handle = h;
    w.sealed = s;
    w.refd   = r;
    w.wrt    = wr;
    w.failed = f;
    return w;
  endfunction

  // given kind, every other field random (ignored fields still toggle)
  function automatic chunk_word_t random_word(input kind_t k);
    return mk(k, $urandom(), 1'($urandom_range(0, 1)), count_t'($urandom()),
              count_t'($urandom()), 1'($urandom_range(0, 1)));
  endfunction

  // small pool so handles collide with the running set, plus extremes
  function automatic handle_t pick_handle();
    case ($urandom_range(0, 15))
      0:       return $urandom();
      1:       return '1;
      2:       return '0;
      default: return handle_t'($urandom_range(1, 12));
    endcase
  endfunction

  function automatic chunk_word_t entry_word();
    chunk_word_t w;
    w        = random_word(KIND_ENTRY);
    w.handle = pick_handle();
    w.sealed = ($urandom_range(0, 6) != 0);
    case ($urandom_range(0, 9))
      0: begin                                   // nothing written
        w.wrt  = '0;
        w.refd = count_t'($urandom_range(0, 3));
      end
      1: begin                                   // full-width counts
        w.wrt  = count_t'($urandom());
        w.refd = count_t'($urandom());
      end
      2: begin                                   // nearly all garbage
        w.wrt  = '1;
        w.refd = count_t'($urandom_range(1, 4));
      end
      3: begin                                   // more referenced than written
        w.wrt  = count_t'($urandom_range(1, 64));
        w.refd = w.wrt + count_t'($urandom_range(1, 8));
      end
      default: begin                             // small counts, ties likely
        w.wrt  = count_t'($urandom_range(1, 64));
        w.refd = count_t'($urandom_range(0, w.wrt));
      end
    endcase
    return w;
  endfunction

  // mostly a chunk that is really running, sometimes an unknown one
  function automatic chunk_word_t finish_word();
    chunk_word_t w;
    int          busy[$];
    w = random_word(KIND_FINISHED);
    for (int i = 0; i < SLOTS; i++)
      if (slot_busy[i]) busy.insert(busy.size(), i);
    if (busy.size() != 0 && $urandom_range(0, 4) != 0)
      w.handle = slot_handle[busy[$urandom_range(0, busy.size() - 1)]];
    else
      w.handle = pick_handle();
    return w;
  endfunction

  function automatic int draw_gap();
    return quiet ? 0 : $urandom_range(0, 17);
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // Offer one word after a random gap and wait for the handshake. Valid stays
  // high across back-to-back words; it only drops when a gap is drawn.
  task automatic send_word(input chunk_word_t w);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid             <= 1'b1;
    in_ch.kind              <= w.kind;
    in_ch.chunk_handle      <= w.handle;
    in_ch.sealed            <= w.sealed;
    in_ch.referenced_blocks <= w.refd;
    in_ch.written_blocks    <= w.wrt;
    in_ch.failed            <= w.failed;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    select_victim(w);
    words_sent++;
  endtask

  // Stop offering, wait for every result, then let the pipeline run dry.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both registers; only called with the block idle.
  task automatic program_selector(input int unsigned maxrun, input int unsigned thresh);
    cfg_we    <= 1'b1;
    cfg_index <= REG_MAX_RUNNING;
    cfg_wdata <= CFG_DATA_W'(maxrun);
    @(posedge clk);
    cfg_index <= REG_GARBAGE_THRESHOLD;
    cfg_wdata <= CFG_DATA_W'(thresh);
    @(posedge clk);
    cfg_we      <= 1'b0;
    lim_running  = maxrun[MAXRUN_W-1:0];
    min_garbage  = thresh[THRESH_W-1:0];
  endtask

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("mismatch %s: got %0h, want %0h (after %0d words)", what, got, want,
             words_sent);
    mismatches++;
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stalls per word, plus the long hold-off on request
  // --------------------------------------------------------------------------
  initial begin : result_ready_drive
    int stall;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold_req) @(posedge clk);
        hold_req = 0;
      end
      stall = draw_gap();
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      // leave early if a hold-off is asked while waiting for a word
      do @(posedge clk);
      while (!(out_ch.valid === 1'b1 && out_ch.ready === 1'b1) && hold_req == 0);
    end
  end

  // Every accepted result word is matched against the oldest expectation.
  initial begin : result_checker
    verdict_t want;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        if (pending_verdicts.size() == 0) begin
          report_mismatch("result word with none expected", out_ch.victim_handle, 0);
        end else begin
          want = pending_verdicts.pop_front();
          if (out_ch.launched !== want.launched)
            report_mismatch("launched", out_ch.launched, want.launched);
          if (out_ch.victim_handle !== want.victim)
            report_mismatch("victim_handle", out_ch.victim_handle, want.victim);
          if (out_ch.error_pending !== want.err)
            report_mismatch("error_pending", out_ch.error_pending, want.err);
        end
      end
    end
  end

  // Ends the run when no word moves on either channel for too long.
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if (rst_n !== 1'b1 || (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
        idle = 0;
      else
        idle++;
    end
    $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Reset registers (max 1, threshold one half): the ratio-equal-to-threshold
  // entry launches, an all-live entry is ignored, then the set is full.
  task automatic test_default_config_launch();
    send_word(mk(KIND_SCAN_BEGIN, '0, 1'b0, '0, '0, 1'b0));
    send_word(mk(KIND_ENTRY, '1, 1'b1, count_t'(1), count_t'(2), 1'b0));
    send_word(mk(KIND_ENTRY, '0, 1'b1, '1, '1, 1'b0));
    send_word(mk(KIND_SCAN_END, '0, 1'b0, '0, '0, 1'b0));
    // one running with max 1: eligible entry must wait
    send_word(mk(KIND_SCAN_BEGIN, '0, 1'b0, '0, '0, 1'b0));
    send_word(mk(KIND_ENTRY, handle_t'(5), 1'b1, count_t'(1), count_t'(4), 1'b0));
    send_word(mk(KIND_SCAN_END, '0, 1'b0, '0, '0, 1'b0));
  endtask

  // Unknown finished handle is dropped; a real one latches its error. Tie goes
  // to the first entry; unsealed and no-live entries never win; a running
  // handle is skipped; the latch clears on an empty end with nothing running.
  task automatic test_finish_and_error_latch();
    send_word(mk(KIND_FINISHED, handle_t'(32'h1234_5678), 1'b0, '0, '0, 1'b1));
    send_word(mk(KIND_FINISHED, '1, 1'b0, '0, '0, 1'b1));
    send_word(mk(KIND_SCAN_BEGIN, '0, 1'b0, '0, '0, 1'b0));
    send_word(mk(KIND_ENTRY, handle_t'(7), 1'b1, count_t'(1), count_t'(8), 1'b0));
    send_word(mk(KIND_ENTRY, handle_t'(8), 1'b1, count_t'(1), count_t'(8), 1'b0));
    send_word(mk(KIND_ENTRY, handle_t'(9), 1'b0, count_t'(1), count_t'(100), 1'b0));
    send_word(mk(KIND_ENTRY, handle_t'(10), 1'b1, '0, count_t'(100), 1'b0));
    send_word(mk(KIND_SCAN_END, '0, 1'b0, '0, '0, 1'b0));
    // entry outside a scan, but its handle is already running
    send_word(mk(KIND_ENTRY, handle_t'(7), 1'b1, count_t'(1), count_t'(1000), 1'b0));
    send_word(mk(KIND_SCAN_END, '0, 1'b0, '0, '0, 1'b0));
    send_word(mk(KIND_FINISHED, handle_t'(7), 1'b0, '0, '0, 1'b1));
    send_word(mk(KIND_SCAN_END, '0, 1'b0, '0, '0, 1'b0));
  endtask

  // Threshold zero: a zero-written entry is eligible, a negative ratio is not,
  // and a later ratio-zero entry does not displace the first.
  task automatic test_zero_threshold_ties();
    settle();
    program_selector(15, 0);
    send_word(mk(KIND_SCAN_BEGIN, '0, 1'b0, '0, '0, 1'b0));
    send_word(mk(KIND_ENTRY, handle_t'(20), 1'b1, count_t'(3), '0, 1'b0));
    send_word(mk(KIND_ENTRY, handle_t'(21), 1'b1, count_t'(5), count_t'(2), 1'b0));
    send_word(mk(KIND_ENTRY, handle_t'(22), 1'b1, count_t'(1), count_t'(1), 1'b0));
    send_word(mk(KIND_SCAN_END, '0, 1'b0, '0, '0, 1'b0));
  endtask

  // Result side held off while scans keep coming without gaps, so the held
  // result word backs up into the input channel.
  task automatic test_result_backpressure();
    settle();
    program_selector(8, 16384);
    hold_req = HOLD_CYCLES;
    quiet    = 1'b1;
    repeat (15) begin
      send_word(random_word(KIND_SCAN_BEGIN));
      send_word(entry_word());
      send_word(random_word(KIND_SCAN_END));
    end
    quiet = 1'b0;
  endtask

  // One scan: mostly well formed, sometimes without begin or end, then some
  // finished events and an occasional word of random kind.
  task automatic scan_round();
    quiet = ($urandom_range(0, 7) == 0);
    if ($urandom_range(0, 9) != 0) send_word(random_word(KIND_SCAN_BEGIN));
    repeat ($urandom_range(1, 6)) send_word(entry_word());
    if ($urandom_range(0, 19) != 0) send_word(random_word(KIND_SCAN_END));
    repeat ($urandom_range(0, 2)) send_word(finish_word());
    if ($urandom_range(0, 9) == 0) send_word(random_word(kind_t'($urandom_range(0, 3))));
  endtask

  // Random scans under a sweep of settings, extremes included: max running
  // zero and above the slot count, threshold zero, one and above one.
  task automatic test_random_scans();
    int unsigned phase_maxrun [PHASES] = '{1, 8, 3, 15, 0, 2, 8, 5};
    int unsigned phase_thresh [PHASES] = '{32768, 0, 49152, 65536, 16384, 131071,
                                           8192, 40000};
    int          phase_start;
    for (int p = 0; p < PHASES; p++) begin
      settle();
      program_selector(phase_maxrun[p], phase_thresh[p]);
      phase_start = words_sent;
      while (words_sent - phase_start < RANDOM_WORDS / PHASES + 1) scan_round();
    end
    quiet = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main_seq
    in_ch.valid             <= 1'b0;
    in_ch.kind              <= KIND_SCAN_BEGIN;
    in_ch.chunk_handle      <= '0;
    in_ch.sealed            <= 1'b0;
    in_ch.referenced_blocks <= '0;
    in_ch.written_blocks    <= '0;
    in_ch.failed            <= 1'b0;
    cfg_we                  <= 1'b0;
    cfg_index               <= REG_MAX_RUNNING;
    cfg_wdata               <= '0;
    rst_n                   <= 1'b0;

    // model at its reset state
    for (int i = 0; i < SLOTS; i++) begin
      slot_handle[i] = '0;
      slot_busy[i]   = 1'b0;
    end
    forget_candidate();
    fail_latch  = 1'b0;
    lim_running = RST_MAX_RUNNING;
    min_garbage = RST_THRESHOLD;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_config_launch();
    test_finish_and_error_latch();
    test_zero_threshold_ties();
    test_result_backpressure();
    test_random_scans();

    settle();
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/gvs_pkg.sv
design/gvs_if.sv
design/gvs_ratio_cmp.sv
design/greedy_gc_victim_selector_top.sv
test/greedy_gc_victim_selector_top_tb.sv
